### design/rfr_pkg.sv
// Shared types and constants for the remote frame receiver.
package rfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int ADDR_W        = 24;
    localparam int CNT_W         = 5;
    localparam int FRAME_LEN     = 25;
    localparam int SUM_LEN       = 24;
    localparam int HDR_LEN       = 3;
    localparam int PAYLOAD_FIRST = 3;
    localparam int PAYLOAD_LEN   = 20;
    localparam int PAYLOAD_W     = PAYLOAD_LEN * BYTE_W;
    localparam int STATUS_W      = 2;
    localparam int TDATA_W       = 184;

    localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 24'hFF_FFFF;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED      = 2'd0,
        ST_TOO_SHORT     = 2'd1,
        ST_ADDR_MISMATCH = 2'd2,
        ST_SUM_MISMATCH  = 2'd3
    } status_t;

endpackage

### design/remote_frame_receiver.sv
// Top level of the remote frame receiver: byte counter, checksum, payload cell chain, result.
//
// Takes one frame byte per clock cycle with no gaps required between frames.
// Payload bytes 3..22 shift through a row of twenty byte cells as they
// arrive; bytes 0..2 form the destination address and bytes 0..23 are
// summed mod 256 and compared with byte 24. Bytes past the 25th are dropped.
// The transaction carrying tlast produces one result in the next cycle in a
// single-entry output register. The input stalls only while that register
// holds an untaken result and m_tready is low. The address register is
// written through the cfg channel, which is always ready.
module remote_frame_receiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rfr_pkg::ADDR_W-1:0]  cfg_data,     // station_address
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,      // data_byte
    input  logic                        s_tlast,      // frame_end
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // dest_address, rudder_bits, throttle_bits, aileron_bits, elevator_bits,
    // arm_button, flip_button, control_mode, alt_control_mode
    output logic [rfr_pkg::TDATA_W-1:0] m_tdata,
    output logic [rfr_pkg::STATUS_W-1:0] m_tuser      // status
);

    rfr_pkg::addr_t   station_reg;
    rfr_pkg::count_t  count_reg, count_next, count_after;
    rfr_pkg::byte_t   sum_reg, sum_next;
    rfr_pkg::addr_t   hdr_reg, hdr_next, hdr_after;
    logic             match_reg, match_next, match_after;

    logic             m_tvalid_reg, m_tvalid_next;
    rfr_pkg::status_t status_reg, status_next;
    rfr_pkg::addr_t   dest_reg, dest_next;
    logic [rfr_pkg::PAYLOAD_W-1:0] pay_reg, pay_next;

    logic             s_accept;
    logic             in_frame;
    logic             pay_shift;
    rfr_pkg::byte_t   b;
    rfr_pkg::byte_t   cell_q [rfr_pkg::PAYLOAD_LEN];
    logic [rfr_pkg::PAYLOAD_W-1:0] pay_flat;

    assign b         = s_tdata;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_frame  = count_reg < rfr_pkg::CNT_W'(rfr_pkg::FRAME_LEN);
    assign pay_shift = s_accept && in_frame
                     && count_reg >= rfr_pkg::CNT_W'(rfr_pkg::PAYLOAD_FIRST)
                     && count_reg < rfr_pkg::CNT_W'(rfr_pkg::PAYLOAD_FIRST
                                                   + rfr_pkg::PAYLOAD_LEN);

    // byte k of the frame ends up in cell 22-k; cell 0 sits in the top byte
    genvar gi;
    generate
        for (gi = 0; gi < rfr_pkg::PAYLOAD_LEN; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                rfr_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (pay_shift),
                    .d        (b),
                    .q        (cell_q[gi])
                );
            end else begin : g_body
                rfr_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (pay_shift),
                    .d        (cell_q[gi-1]),
                    .q        (cell_q[gi])
                );
            end
            assign pay_flat[rfr_pkg::PAYLOAD_W-1-rfr_pkg::BYTE_W*gi -: rfr_pkg::BYTE_W] =
                cell_q[gi];
        end
    endgenerate

    always_comb begin
        count_after = count_reg;
        hdr_after   = hdr_reg;
        match_after = match_reg;
        sum_next    = sum_reg;
        if (in_frame) begin
            count_after = count_reg + rfr_pkg::CNT_W'(1);
            if (count_reg < rfr_pkg::CNT_W'(rfr_pkg::HDR_LEN)) begin
                hdr_after = {hdr_reg[rfr_pkg::ADDR_W-rfr_pkg::BYTE_W-1:0], b};
            end
            if (count_reg < rfr_pkg::CNT_W'(rfr_pkg::SUM_LEN)) begin
                sum_next = sum_reg + b;
            end else begin
                match_after = (b == sum_reg);
            end
        end

        count_next    = count_reg;
        hdr_next      = hdr_reg;
        match_next    = match_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        dest_next     = dest_reg;
        pay_next      = pay_reg;

        if (s_accept) begin
            count_next = count_after;
            hdr_next   = hdr_after;
            match_next = match_after;
            if (s_tlast) begin
                count_next    = '0;
                hdr_next      = '0;
                match_next    = 1'b0;
                sum_next      = '0;
                m_tvalid_next = 1'b1;
                dest_next     = '0;
                pay_next      = '0;
                if (count_after < rfr_pkg::CNT_W'(rfr_pkg::FRAME_LEN)) begin
                    status_next = rfr_pkg::ST_TOO_SHORT;
                end else begin
                    dest_next = hdr_after;
                    if (hdr_after != station_reg && hdr_after != rfr_pkg::BROADCAST_ADDR) begin
                        status_next = rfr_pkg::ST_ADDR_MISMATCH;
                    end else if (!match_after) begin
                        status_next = rfr_pkg::ST_SUM_MISMATCH;
                    end else begin
                        status_next = rfr_pkg::ST_ACCEPTED;
                        pay_next    = pay_flat;
                    end
                end
            end
        end else begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg  <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            hdr_reg      <= '0;
            match_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                station_reg <= cfg_data;
            end
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            hdr_reg      <= hdr_next;
            match_reg    <= match_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        dest_reg   <= dest_next;
        pay_reg    <= pay_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {pay_reg, dest_reg};

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rfr_pkg::CNT_W'(rfr_pkg::FRAME_LEN))
        else $error("byte count past frame length");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> m_tvalid_reg && count_reg == '0 && sum_reg == '0)
        else $error("frame end did not produce a result or clear state");

    a_pay_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && status_reg != rfr_pkg::ST_ACCEPTED |-> pay_reg == '0)
        else $error("payload not zero on rejected frame");

    a_short_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && status_reg == rfr_pkg::ST_TOO_SHORT |-> dest_reg == '0)
        else $error("destination not zero on short frame");

    a_no_shift_late: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= rfr_pkg::CNT_W'(rfr_pkg::PAYLOAD_FIRST + rfr_pkg::PAYLOAD_LEN)
        |-> !pay_shift)
        else $error("payload chain shifted outside payload bytes");

endmodule

### design/rfr_cell.sv
// One byte cell of the payload shift chain.
module rfr_cell (
    input  logic           aclk,
    input  logic           shift_en,
    input  rfr_pkg::byte_t d,
    output rfr_pkg::byte_t q
);

    rfr_pkg::byte_t q_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule
